>>> src/dttf_pkg.sv
// Shared types, character codes and tables for the decimal text to fixed-point converter.
`timescale 1ns / 1ps

package dttf_pkg;

  // Fixed widths of the payload
  localparam int VALUE_W = 48;
  localparam int CHAR_W  = 8;

  // Parameter defaults
  localparam int DEF_INT_BITS        = 32;
  localparam int DEF_FRAC_BITS       = 16;
  localparam int DEF_MAX_FRAC_DIGITS = 6;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [CHAR_W-1:0] char_byte;
    logic              last_byte;
  } char_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      overflow;
  } result_item_t;

  // Parse phase of the current buffer
  typedef enum logic [1:0] {
    PH_LEAD,
    PH_INT,
    PH_FRAC,
    PH_STOP
  } phase_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_PARSE,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic parse_en;
    logic div_load;
    logic div_step;
    logic emit;
  } dttf_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } dttf_status_t;

  // Powers of ten for the fraction scaling, up to seven digits
  function automatic logic [23:0] pow10(input logic [2:0] n);
    logic [23:0] p;
    case (n)
      3'd0:    p = 24'd1;
      3'd1:    p = 24'd10;
      3'd2:    p = 24'd100;
      3'd3:    p = 24'd1000;
      3'd4:    p = 24'd10000;
      3'd5:    p = 24'd100000;
      3'd6:    p = 24'd1000000;
      default: p = 24'd10000000;
    endcase
    return p;
  endfunction

  // Bits needed for a decimal integer of n digits
  function automatic int frac_acc_width(input int n);
    int w;
    case (n)
      1:       w = 4;
      2:       w = 7;
      3:       w = 10;
      4:       w = 14;
      5:       w = 17;
      6:       w = 20;
      default: w = 24;
    endcase
    return w;
  endfunction

endpackage

>>> src/decimal_text_to_fixed.sv
// Top level of the decimal text to signed fixed-point converter.
`timescale 1ns / 1ps
// Sequence: a byte without the final flag is taken while parsing; after the final
//   byte the controller passes through divider load, divide steps and result emit.
// Throughput: one byte per cycle inside a buffer; the final byte then holds the
//   input stalled while the fraction divider runs one quotient bit per cycle,
//   plus any wait for the output register to drain.
// Reset: synchronous rst clears the controller, the parse state and result_valid.

module decimal_text_to_fixed #(
  parameter int INT_BITS        = dttf_pkg::DEF_INT_BITS,
  parameter int FRAC_BITS       = dttf_pkg::DEF_FRAC_BITS,
  parameter int MAX_FRAC_DIGITS = dttf_pkg::DEF_MAX_FRAC_DIGITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   char_valid,
  output logic                   char_stall,
  input  dttf_pkg::char_item_t   chars,
  output logic                   result_valid,
  input  logic                   result_stall,
  output dttf_pkg::result_item_t result
);
  import dttf_pkg::*;

  // Command and status between the controller and the datapath
  dttf_cmd_t    cmd;
  dttf_status_t status;

  // Controller: takes a character transfer in the parse state, then sequences
  // the divider load, the FRAC_BITS divide steps and the result hand-off.
  dttf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .last_byte  (chars.last_byte),
    .char_stall (char_stall),
    .status     (status),
    .cmd        (cmd)
  );

  // Datapath: parse registers advance on each character, the divider scales
  // the kept fraction digits to binary, the output register holds the result
  // until its transfer completes.
  dttf_datapath #(
    .INT_BITS        (INT_BITS),
    .FRAC_BITS       (FRAC_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .char_byte    (chars.char_byte),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

>>> src/dttf_ctrl.sv
// Controller state machine: parse, divider load, divide steps, result hand-off.
`timescale 1ns / 1ps

module dttf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  input  logic                last_byte,
  output logic                char_stall,
  input  dttf_pkg::dttf_status_t status,
  output dttf_pkg::dttf_cmd_t    cmd
);
  import dttf_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_PARSE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    char_stall = 1'b1;
    case (state)
      ST_PARSE: begin
        char_stall   = 1'b0;
        cmd.parse_en = char_valid;
        if (char_valid && last_byte) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.div_load = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // hold until the output register can take the result
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_PARSE;
        end
      end
      default: begin
        state_next = ST_PARSE;
      end
    endcase
  end

endmodule

>>> src/dttf_datapath.sv
// Datapath: parse registers, fraction divider and output register.
`timescale 1ns / 1ps

module dttf_datapath #(
  parameter int INT_BITS        = dttf_pkg::DEF_INT_BITS,
  parameter int FRAC_BITS       = dttf_pkg::DEF_FRAC_BITS,
  parameter int MAX_FRAC_DIGITS = dttf_pkg::DEF_MAX_FRAC_DIGITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [dttf_pkg::CHAR_W-1:0] char_byte,
  input  dttf_pkg::dttf_cmd_t        cmd,
  output dttf_pkg::dttf_status_t     status,
  output logic                       result_valid,
  input  logic                       result_stall,
  output dttf_pkg::result_item_t     result
);
  import dttf_pkg::*;

  localparam int EIB    = (INT_BITS < VALUE_W - FRAC_BITS) ? INT_BITS : VALUE_W - FRAC_BITS;
  localparam int IW     = EIB - 1;
  localparam int MW     = IW + FRAC_BITS;
  localparam int FACC_W = frac_acc_width(MAX_FRAC_DIGITS);
  localparam int CNT_W  = $clog2(FRAC_BITS);
  localparam logic [IW-1:0]      IMAX       = '1;
  localparam logic [2:0]         FRAC_LIMIT = 3'(MAX_FRAC_DIGITS);
  localparam logic [VALUE_W-1:0] SAT_POS    = {{(VALUE_W-MW){1'b0}}, {MW{1'b1}}};

  // Parse registers
  phase_t             phase, phase_next;
  logic               negative, negative_next;
  logic [IW-1:0]      integer_acc, integer_acc_next;
  logic [FACC_W-1:0]  fraction_acc, fraction_acc_next;
  logic [2:0]         fraction_count, fraction_count_next;
  logic               saturated, saturated_next;

  // Divider registers
  logic [FACC_W-1:0]    rem, divisor;
  logic [FRAC_BITS-1:0] quot;
  logic [CNT_W-1:0]     step_cnt;

  logic              is_digit;
  logic [3:0]        digit;
  logic [IW+3:0]     int_wide;
  logic              int_over;
  logic [FACC_W-1:0] frac_wide;
  logic              take_int;
  logic [FACC_W:0]   rem_shift;
  logic              qbit;
  logic [FACC_W-1:0] rem_next;
  logic [MW-1:0]     mag;
  logic [VALUE_W-1:0] mag_ext;
  logic [VALUE_W-1:0] value_next;

  assign is_digit  = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
  assign digit     = 4'(char_byte - CH_ZERO);
  assign int_wide  = ({4'b0, integer_acc} << 3) + ({4'b0, integer_acc} << 1) + (IW+4)'(digit);
  assign int_over  = saturated || (int_wide > {4'b0, IMAX});
  assign frac_wide = (fraction_acc << 3) + (fraction_acc << 1) + FACC_W'(digit);

  always_comb begin
    phase_next          = phase;
    negative_next       = negative;
    integer_acc_next    = integer_acc;
    fraction_acc_next   = fraction_acc;
    fraction_count_next = fraction_count;
    saturated_next      = saturated;
    take_int            = 1'b0;
    case (phase)
      PH_LEAD: begin
        if (char_byte == CH_MINUS) begin
          negative_next = 1'b1;
          phase_next    = PH_INT;
        end else if (char_byte != CH_SPACE) begin
          take_int = 1'b1;
        end
      end
      PH_INT: begin
        take_int = 1'b1;
      end
      PH_FRAC: begin
        if (!is_digit) begin
          phase_next = PH_STOP;
        end else if (fraction_count < FRAC_LIMIT) begin
          fraction_acc_next   = frac_wide;
          fraction_count_next = fraction_count + 3'd1;
        end
      end
      default: begin
      end
    endcase
    if (take_int) begin
      if (is_digit) begin
        phase_next = PH_INT;
        if (int_over) begin
          integer_acc_next = IMAX;
          saturated_next   = 1'b1;
        end else begin
          integer_acc_next = int_wide[IW-1:0];
        end
      end else if (char_byte == CH_POINT || char_byte == CH_COMMA) begin
        phase_next = PH_FRAC;
      end else begin
        phase_next = PH_STOP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      phase          <= PH_LEAD;
      negative       <= 1'b0;
      integer_acc    <= '0;
      fraction_acc   <= '0;
      fraction_count <= '0;
      saturated      <= 1'b0;
    end else if (cmd.parse_en) begin
      phase          <= phase_next;
      negative       <= negative_next;
      integer_acc    <= integer_acc_next;
      fraction_acc   <= fraction_acc_next;
      fraction_count <= fraction_count_next;
      saturated      <= saturated_next;
    end
  end

  // Restoring division, one quotient bit per step
  assign rem_shift = {rem, 1'b0};
  assign qbit      = rem_shift >= {1'b0, divisor};
  assign rem_next  = qbit ? FACC_W'(rem_shift - {1'b0, divisor}) : rem_shift[FACC_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem      <= fraction_acc;
      divisor  <= FACC_W'(pow10(fraction_count));
      quot     <= '0;
      step_cnt <= '0;
    end else if (cmd.div_step) begin
      rem      <= rem_next;
      quot     <= {quot[FRAC_BITS-2:0], qbit};
      step_cnt <= step_cnt + CNT_W'(1);
    end
  end

  assign status.div_last = step_cnt == CNT_W'(FRAC_BITS - 1);
  assign status.out_free = !result_valid || !result_stall;

  assign mag     = {integer_acc, quot};
  assign mag_ext = VALUE_W'(mag);

  always_comb begin
    if (saturated) begin
      value_next = negative ? ~SAT_POS : SAT_POS;
    end else begin
      value_next = negative ? (VALUE_W'(0) - mag_ext) : mag_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.value    <= value_next;
      result.overflow <= saturated;
    end
  end

  // Never overwrite a result that is still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!result_valid || !result_stall))
    else $error("result emitted over a pending transfer");

  // Partial remainder stays below the divisor while dividing
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (rem < divisor))
    else $error("divider remainder out of range");

  // Emit starts a fresh buffer
  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (phase == PH_LEAD && !saturated && fraction_count == 3'd0))
    else $error("parse state not cleared after emit");

  // Saturation pins the integer accumulator to its limit
  a_sat_pinned: assert property (@(posedge clk) disable iff (rst)
    saturated |-> (integer_acc == IMAX))
    else $error("saturated without integer at limit");

endmodule

>>> tb/tb_decimal_text_to_fixed.sv
// Self-checking testbench for the decimal text to signed fixed-point converter.
`timescale 1ns / 1ps

module tb_decimal_text_to_fixed;
  import dttf_pkg::*;

  // Output format at the default parameters: the integer part is capped so the
  // whole number fits the 48-bit value field.
  localparam int FRAC_W = DEF_FRAC_BITS;
  localparam int INT_W  = (DEF_INT_BITS < VALUE_W - DEF_FRAC_BITS) ?
                          DEF_INT_BITS : VALUE_W - DEF_FRAC_BITS;
  localparam logic [63:0] INT_LIMIT = (64'd1 << (INT_W - 1)) - 64'd1;

  // Settle time after the last result: divider run plus a small margin
  localparam int DRAIN_CYCLES = DEF_FRAC_BITS + 8;
  // Length of the long receiver hold-off
  localparam int LONG_HOLD    = 300;
  // Characters per random phase
  localparam int RANDOM_CHARS = 550;

  logic         clk          = 1'b0;
  logic         rst          = 1'b1;
  logic         char_valid   = 1'b0;
  logic         char_stall;
  char_item_t   chars        = '0;
  logic         result_valid;
  logic         result_stall = 1'b0;
  result_item_t result;

  decimal_text_to_fixed u_dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .chars        (chars),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Parser shadow state, advanced on every accepted character
  phase_t      num_phase;
  logic        num_negative;
  logic [63:0] int_mag;
  logic [63:0] frac_val;
  int          frac_digit_cnt;
  logic        int_saturated;

  // Numbers the block still owes, oldest first
  result_item_t expected_results[$];

  // Idle rates in percent of cycles, set per test phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Long hold-off handshake: tests bump the request count, the receiver serves it
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  // Run statistics
  int errors          = 0;
  int chars_sent      = 0;
  int numbers_checked = 0;
  int overflows_seen  = 0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_number();
    num_phase      = PH_LEAD;
    num_negative   = 1'b0;
    int_mag        = '0;
    frac_val       = '0;
    frac_digit_cnt = 0;
    int_saturated  = 1'b0;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Integer phase: accumulate a digit with saturation, move on at a separator,
  // stop at anything else.
  function automatic void take_int_char(input logic [7:0] c);
    logic [63:0] d;
    d = {56'd0, c - CH_ZERO};
    if (is_digit(c)) begin
      if (int_saturated || int_mag > (INT_LIMIT - d) / 64'd10) begin
        int_mag       = INT_LIMIT;
        int_saturated = 1'b1;
      end else begin
        int_mag = int_mag * 64'd10 + d;
      end
      num_phase = PH_INT;
    end else if (c == CH_POINT || c == CH_COMMA) begin
      num_phase = PH_FRAC;
    end else begin
      num_phase = PH_STOP;
    end
  endfunction

  // Fraction phase: keep digits up to the limit, drop the rest
  function automatic void take_frac_char(input logic [7:0] c);
    if (!is_digit(c)) begin
      num_phase = PH_STOP;
    end else if (frac_digit_cnt < DEF_MAX_FRAC_DIGITS && frac_digit_cnt < 7) begin
      frac_val       = frac_val * 64'd10 + {56'd0, c - CH_ZERO};
      frac_digit_cnt = frac_digit_cnt + 1;
    end
  endfunction

  // Fixed-point number for the current shadow state
  function automatic result_item_t fixed_number();
    result_item_t r;
    logic [63:0]  mag;
    logic [63:0]  scale;
    int           i;
    scale = 64'd1;
    for (i = 0; i < frac_digit_cnt; i++) scale = scale * 64'd10;
    if (int_saturated) begin
      if (num_negative) mag = 64'd0 - (64'd1 << (INT_W - 1 + FRAC_W));
      else              mag = (INT_LIMIT << FRAC_W) | ((64'd1 << FRAC_W) - 64'd1);
    end else begin
      // Truncating fraction scale; negation then truncates toward zero
      mag = (int_mag << FRAC_W) + ((frac_val << FRAC_W) / scale);
      if (num_negative) mag = 64'd0 - mag;
    end
    r.value    = mag[VALUE_W-1:0];
    r.overflow = int_saturated;
    return r;
  endfunction

  function automatic void predict_char(input char_item_t item);
    case (num_phase)
      PH_LEAD: begin
        if (item.char_byte == CH_SPACE) begin
          // skip leading space
        end else if (item.char_byte == CH_MINUS) begin
          num_negative = 1'b1;
          num_phase    = PH_INT;
        end else begin
          take_int_char(item.char_byte);
        end
      end
      PH_INT:  take_int_char(item.char_byte);
      PH_FRAC: take_frac_char(item.char_byte);
      default: ;
    endcase
    // The final byte is parsed first, then the number is due
    if (item.last_byte) begin
      expected_results.push_back(fixed_number());
      clear_number();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    errors = errors + 1;
    $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  task automatic check_number(input result_item_t got);
    result_item_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected number value=%0d overflow=%0b",
                                got.value, got.overflow));
    end else begin
      want = expected_results.pop_front();
      if (got.value !== want.value)
        report_mismatch($sformatf("number %0d: value %0d, expected %0d",
                                  numbers_checked, got.value, want.value));
      if (got.overflow !== want.overflow)
        report_mismatch($sformatf("number %0d: overflow %0b, expected %0b",
                                  numbers_checked, got.overflow, want.overflow));
      if (want.overflow) overflows_seen = overflows_seen + 1;
    end
    numbers_checked = numbers_checked + 1;
  endtask

  // Receiver: sample the transfer with pre-edge values, then pick the next
  // stall. A pending long hold-off overrides the random stall.
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_served + 1;
      hold_left   = LONG_HOLD;
    end
    if (!rst && result_valid && !result_stall) check_number(result);
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Offer one character and wait for its transfer. Valid is left high on
  // return, so back-to-back characters keep it up; gaps lower it first.
  task automatic send_char(input logic [7:0] c, input logic last);
    char_item_t item;
    item.char_byte = c;
    item.last_byte = last;
    while ($urandom_range(99) < send_idle_pct) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    chars      <= item;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    predict_char(item);
    chars_sent = chars_sent + 1;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  // Hold the sender off until every owed number has come out
  task automatic pause_until_drained();
    char_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] random_digit();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  // One random buffer: mostly well-formed numbers with random content, the
  // rest broken numbers and raw byte noise.
  task automatic send_random_number();
    logic [7:0] text[$];
    int         kind;
    int         n;
    int         i;
    kind = $urandom_range(99);
    if (kind < 85) begin
      repeat ($urandom_range(3) == 0 ? $urandom_range(1, 3) : 0) text.push_back(CH_SPACE);
      if ($urandom_range(1)) text.push_back(CH_MINUS);
      // Long integer parts reach the saturation region
      n = ($urandom_range(9) == 0) ? $urandom_range(9, 13) : $urandom_range(5);
      repeat (n) text.push_back(random_digit());
      if ($urandom_range(9) < 7) begin
        text.push_back($urandom_range(1) ? CH_POINT : CH_COMMA);
        repeat ($urandom_range(9)) text.push_back(random_digit());
      end
      if ($urandom_range(9) == 0) text.push_back(8'($urandom_range(255)));
      if (kind >= 70 && text.size() > 0) begin
        // Break it: overwrite one position with a random byte
        i = $urandom_range(text.size() - 1);
        text[i] = 8'($urandom_range(255));
      end
    end else begin
      repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(255)));
    end
    if (text.size() == 0) text.push_back(random_digit());
    for (i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Plain numbers: digits, both separators, fraction limit, final byte parsed
  task automatic test_plain_numbers();
    send_text("0");
    send_text("7");
    send_text("123.5");
    send_text("-42,25");
    send_text("  9.999999");
    send_text("3.1415926535");
    send_text("0.000001");
    pause_until_drained();
  endtask

  // Corner cases of the parse rules and of the byte field
  task automatic test_corner_cases();
    send_text("   ");
    send_text("-");
    send_text("abc");
    send_text("-0");
    send_text("- 5");
    send_text("12x34");
    send_text("1.2.3");
    send_text("-.5");
    send_text(".5");
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    pause_until_drained();
  endtask

  // Integer saturation at both signs, with digits after it still consumed
  task automatic test_saturation();
    send_text("2147483647.999999");
    send_text("2147483648");
    send_text("-2147483647");
    send_text("-2147483648");
    send_text("-99999999999.5");
    pause_until_drained();
  endtask

  // Hold the receiver off while the sender keeps offering, so the block
  // fills and stalls its input
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests = hold_requests + 1;
    repeat (12) send_random_number();
    pause_until_drained();
  endtask

  task automatic test_random_numbers(input int snd_pct, input int rcv_pct);
    int start;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    start = chars_sent;
    while (chars_sent - start < RANDOM_CHARS) send_random_number();
    pause_until_drained();
  endtask

  initial begin
    clear_number();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_plain_numbers();
    test_corner_cases();
    test_saturation();
    test_output_backpressure();
    test_random_numbers(23, 65);
    test_random_numbers(65, 23);
    test_random_numbers(0, 0);

    $display("Run covered %0d characters and %0d numbers, %0d of them saturated,",
             chars_sent, numbers_checked, overflows_seen);
    $display("under sender and receiver idling and one long output hold-off.");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("Mismatches: %0d, numbers still owed: %0d", errors, expected_results.size());
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far above the slowest correct run
  initial begin
    #20_000_000;
    $display("Timeout with %0d numbers still owed", expected_results.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
